// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry layout, command and status codes, and the per-slot operation code.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned TagW  = 16;
  localparam int unsigned PrioW = 16;
  localparam int unsigned HeldW = 5;

  // Command field codes
  localparam logic CmdEnqueue = 1'b0;
  localparam logic CmdDequeue = 1'b1;

  // Result status codes
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic [TagW-1:0]         tag;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  // One slot as seen by its neighbors
  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  typedef enum logic [1:0] {
    SlotHold     = 2'd0,
    SlotLoad     = 2'd1,
    SlotFromPrev = 2'd2,
    SlotFromNext = 2'd3
  } slot_op_e;

  // Control handed from the queue controller to one slot
  typedef struct packed {
    slot_op_e op;
  } slot_ctl_t;

endpackage

// ----- src/spq_slot.sv -----
// ----------------------------------------------------------------------------
// spq_slot: one slot of the sorted entry chain
// Holds one entry and its valid bit, compares its priority against the
// incoming entry, and loads from the new entry or a neighbor on command.
// ----------------------------------------------------------------------------
module spq_slot
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  slot_ctl_t ctl_i,
  input  entry_t    new_i,
  input  slot_t     prev_i,
  input  slot_t     next_i,
  output slot_t     slot_o,
  output logic      move_o
);

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;

  // Flag a held entry that must step toward the tail to make room
  assign move_o = valid_q && (ent_q.prio < new_i.prio);

  // Select the next content of the slot
  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    case (ctl_i.op)
      SlotHold: begin
      end
      SlotLoad: begin
        valid_d = 1'b1;
        ent_d   = new_i;
      end
      SlotFromPrev: begin
        valid_d = prev_i.valid;
        ent_d   = prev_i.ent;
      end
      SlotFromNext: begin
        valid_d = next_i.valid;
        ent_d   = next_i.ent;
      end
      default: begin
      end
    endcase
  end

  // Hold the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.ent   = ent_q;

endmodule

// ----- src/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue on a chain of compare-and-shift slots
// Entries stay sorted by descending priority, head at slot 0; equal
// priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  in      | input     | in_valid_i/in_ready_o | cmd_i, item_tag_i, item_priority_i
//  out     | output    | out_valid_o/out_ready_i | status_o, out_tag_o,
//          |           |                       | out_priority_o, entries_held_o
//
//  One beat per cycle: every slot compares and shifts in the same cycle.
//  The result is registered and appears in the cycle after its beat is accepted.
//  A new beat is taken while the output register is empty or being drained;
//  a stalled output holds the input off.
//  Reset clears all valid bits and the count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [TagW-1:0]         item_tag_i,
  input  logic signed [PrioW-1:0] item_priority_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [TagW-1:0]         out_tag_o,
  output logic signed [PrioW-1:0] out_priority_o,
  output logic [HeldW-1:0]        entries_held_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            full, empty, accept, do_enq, do_deq;
  entry_t          new_ent;

  slot_t     slots [DEPTH];
  logic      move  [DEPTH];
  slot_ctl_t ctl   [DEPTH];

  logic                    out_valid_q;
  logic [1:0]              status_q, status_d;
  logic [TagW-1:0]         tag_q, tag_d;
  logic signed [PrioW-1:0] prio_q, prio_d;
  logic [HeldW-1:0]        held_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);
  assign do_enq     = accept && (cmd_i == CmdEnqueue) && !full;
  assign do_deq     = accept && (cmd_i == CmdDequeue) && !empty;

  assign new_ent.tag  = item_tag_i;
  assign new_ent.prio = item_priority_i;

  // Build the slot chain and decide each slot's move
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    slot_t prev_s, next_s;
    logic  prev_move, prev_valid, load_here;

    if (i == 0) begin : g_head
      assign prev_s     = '0;
      assign prev_move  = 1'b0;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_s     = slots[i-1];
      assign prev_move  = move[i-1];
      assign prev_valid = slots[i-1].valid;
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_mid
      assign next_s = slots[i+1];
    end

    // New entry lands at the first slot that is free or ranks below it
    assign load_here = prev_valid && !prev_move && (move[i] || !slots[i].valid);

    always_comb begin
      if (do_enq && prev_move) begin
        ctl[i].op = SlotFromPrev;
      end else if (do_enq && load_here) begin
        ctl[i].op = SlotLoad;
      end else if (do_deq) begin
        ctl[i].op = SlotFromNext;
      end else begin
        ctl[i].op = SlotHold;
      end
    end

    spq_slot u_slot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[i]),
      .new_i  (new_ent),
      .prev_i (prev_s),
      .next_i (next_s),
      .slot_o (slots[i]),
      .move_o (move[i])
    );
  end

  // Update the entry count and form the result
  always_comb begin
    count_d  = count_q;
    status_d = StatusDone;
    tag_d    = '0;
    prio_d   = '0;
    if (cmd_i == CmdEnqueue) begin
      if (full) begin
        status_d = StatusFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StatusEmpty;
      end else begin
        count_d = count_q - CntW'(1);
        tag_d   = slots[0].ent.tag;
        prio_d  = slots[0].ent.prio;
      end
    end
  end

  // Hold the count and the output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      prio_q   <= prio_d;
      held_q   <= HeldW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_tag_o      = tag_q;
  assign out_priority_o = prio_q;
  assign entries_held_o = held_q;

endmodule

// ----- src/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the handshakes and result beats on the top level's ports.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    cmd_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [1:0]              status_o,
  input logic [TagW-1:0]         out_tag_o,
  input logic signed [PrioW-1:0] out_priority_o,
  input logic [HeldW-1:0]        entries_held_o
);

  localparam logic [HeldW-1:0] FullHeld = HeldW'(DEPTH);

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(out_tag_o) && $stable(out_priority_o) && $stable(entries_held_o))
    else $error("stalled result beat changed");

  // Every accepted beat yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // An enqueue never reports empty and returns no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CmdEnqueue |=>
      status_o != StatusEmpty && out_tag_o == '0 && out_priority_o == '0)
    else $error("enqueue returned an entry or empty status");

  // Full and empty reports agree with the held count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusFull |-> entries_held_o == FullHeld)
    else $error("full status with wrong count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusEmpty |->
      entries_held_o == '0 && out_tag_o == '0 && out_priority_o == '0)
    else $error("empty status with nonzero data or count");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

// ----- tb/tb_sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// Drives enqueue and dequeue beats through the valid/ready input channel and
// tracks the sorted entry list alongside the block. Every output beat is
// checked field by field against the oldest predicted result. Random traffic
// runs under four idling patterns, one of them with a long output hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0]                       status;
  logic [spq_pkg::TagW-1:0]         tag;
  logic signed [spq_pkg::PrioW-1:0] prio;
  logic [spq_pkg::HeldW-1:0]        held;
} spq_result_t;

// Keeps its own sorted entry list and the results still owed by the block
class spq_order_checker;
  int unsigned       depth;
  spq_pkg::entry_t   sorted_entries[$];
  spq_result_t       owed_results[$];
  int unsigned       mismatches;

  function new(int unsigned depth_val);
    depth       = depth_val;
    mismatches  = 0;
  endfunction

  function int unsigned owed_count();
    return owed_results.size();
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Apply one accepted input beat to the sorted list and predict its result
  function void note_request(logic cmd, logic [spq_pkg::TagW-1:0] tag,
                             logic signed [spq_pkg::PrioW-1:0] prio);
    spq_pkg::entry_t ent;
    spq_result_t     res;
    int              pos;
    res = '0;
    if (cmd == spq_pkg::CmdEnqueue) begin
      if (sorted_entries.size() >= depth) begin
        res.status = spq_pkg::StatusFull;
      end else begin
        // insert behind every entry of greater or equal priority
        pos = sorted_entries.size();
        while (pos > 0 && $signed(sorted_entries[pos-1].prio) < $signed(prio)) pos--;
        ent.tag  = tag;
        ent.prio = prio;
        sorted_entries.insert(pos, ent);
        res.status = spq_pkg::StatusDone;
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = spq_pkg::StatusEmpty;
      end else begin
        ent        = sorted_entries.pop_front();
        res.status = spq_pkg::StatusDone;
        res.tag    = ent.tag;
        res.prio   = ent.prio;
      end
    end
    res.held = spq_pkg::HeldW'(sorted_entries.size());
    owed_results.push_back(res);
  endfunction

  // Compare one output beat with the oldest owed result
  function void check_response(spq_result_t got);
    spq_result_t exp;
    if (owed_results.size() == 0) begin
      flag($sformatf("unexpected beat status %0d tag %h prio %0d held %0d",
                     got.status, got.tag, got.prio, got.held));
      return;
    end
    exp = owed_results.pop_front();
    if (exp.status != got.status || exp.tag != got.tag ||
        exp.prio != got.prio || exp.held != got.held)
      flag($sformatf({"expected status %0d tag %h prio %0d held %0d, ",
                      "got status %0d tag %h prio %0d held %0d"},
                     exp.status, exp.tag, exp.prio, exp.held,
                     got.status, got.tag, got.prio, got.held));
  endfunction

  // Flag every result the block never delivered
  function void close();
    while (owed_results.size() != 0) begin
      void'(owed_results.pop_front());
      flag("result never delivered");
    end
  endfunction
endclass

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QDepth     = DefaultDepth;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 430;

  // Idling patterns
  localparam int IdleNone     = 0;
  localparam int IdleSender   = 1;
  localparam int IdleReceiver = 2;
  localparam int IdleBoth     = 3;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    cmd_i = CmdEnqueue;
  logic [TagW-1:0]         item_tag_i = '0;
  logic signed [PrioW-1:0] item_priority_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              status_o;
  logic [TagW-1:0]         out_tag_o;
  logic signed [PrioW-1:0] out_priority_o;
  logic [HeldW-1:0]        entries_held_o;

  int               idle_mode = IdleNone;
  int               hold_off_left = 0;
  int unsigned      cycle_count = 0;
  spq_order_checker order_chk = new(QDepth);

  sorted_priority_queue #(
    .DEPTH(QDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .item_tag_i     (item_tag_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_priority_o (out_priority_o),
    .entries_held_o (entries_held_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  function automatic bit roll_idle(int mode_hit);
    if (idle_mode == mode_hit) return $urandom_range(99) < 84;
    if (idle_mode == IdleBoth) return $urandom_range(99) < 18;
    return 1'b0;
  endfunction

  // Drive output ready: long hold-off first, then the pattern's random stalls
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && !roll_idle(IdleReceiver);
    end
  end

  // Check every output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      order_chk.check_response('{status_o, out_tag_o, out_priority_o, entries_held_o});
  end

  // Offer one beat and hold it until accepted
  task automatic send_beat(logic cmd, logic [TagW-1:0] tag, logic signed [PrioW-1:0] prio);
    @(negedge clk_i);
    while (roll_idle(IdleSender)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    item_tag_i      <= tag;
    item_priority_i <= prio;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    order_chk.note_request(cmd, tag, prio);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (order_chk.owed_count() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [PrioW-1:0] pick_priority();
    case ($urandom_range(3))
      0: return PrioW'($urandom_range(6) - 3);   // narrow band to force ties
      1: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return PrioW'($urandom());
    endcase
  endfunction

  // Random traffic in segments with a drifting enqueue share, so the
  // queue swings between empty and full
  task automatic run_random(int unsigned beats);
    int unsigned sent;
    int unsigned seg_left;
    int unsigned enq_pct;
    sent = 0;
    seg_left = 0;
    enq_pct = 50;
    while (sent < beats) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0: enq_pct = 15;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      send_beat(($urandom_range(99) < enq_pct) ? CmdEnqueue : CmdDequeue,
                TagW'($urandom()), pick_priority());
      seg_left--;
      sent++;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty dequeue, extremes, ties, fill to full, partial drain
    send_beat(CmdDequeue, 16'h0000, 16'sh0000);
    send_beat(CmdEnqueue, 16'h0000, 16'sh7fff);
    send_beat(CmdEnqueue, 16'hffff, 16'sh8000);
    send_beat(CmdEnqueue, 16'h0001, 16'sh0000);
    send_beat(CmdEnqueue, 16'h0002, 16'sh0000);
    send_beat(CmdEnqueue, 16'h0003, 16'sh0000);
    send_beat(CmdEnqueue, 16'haaaa, 16'shffff);
    send_beat(CmdEnqueue, 16'h5555, 16'sh0001);
    send_beat(CmdEnqueue, 16'h0004, 16'sh7fff);
    send_beat(CmdEnqueue, 16'h0005, 16'sh8000);
    for (int i = 0; i < 7; i++) send_beat(CmdEnqueue, TagW'(16'h0100 + i), PrioW'($urandom()));
    send_beat(CmdEnqueue, 16'hffff, 16'sh7fff);
    for (int i = 0; i < 6; i++) send_beat(CmdDequeue, 16'hffff, 16'shffff);
    wait_drained();

    // Random phases; the first one opens with a long output hold-off
    for (int phase = IdleNone; phase <= IdleBoth; phase++) begin
      idle_mode = phase;
      if (phase == IdleNone) hold_off_left = 80;
      run_random(PhaseBeats);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    order_chk.close();
    if (order_chk.mismatches == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
